// ===== rtl/vfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Variable fractional delay line package
// Shared constants for the delay line, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package vfd_pkg;

	// Delay time is unsigned Q24; one extra bit holds the value 1.0 itself.
	localparam int DELAY_FRAC_BITS = 24;
	localparam int DELAY_BITS      = DELAY_FRAC_BITS + 1;
	localparam logic [DELAY_BITS-1:0] DELAY_ONE = DELAY_BITS'(1) << DELAY_FRAC_BITS;

	// Interpolation weight taken from the top of the fractional part.
	localparam int WEIGHT_BITS = 16;

	// Result queue; the outstanding count never exceeds its depth.
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = 2;
	localparam int CNT_BITS   = OUTQ_AW + 1;

endpackage

// ===== rtl/vfd_if.sv =====
// ----------------------------------------------------------------------------
// Delay line channel interfaces
// Valid/ready channels for the input beat and the result beat.
// ----------------------------------------------------------------------------
interface vfd_in_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                                valid;
	logic                                ready;
	logic signed [SAMPLE_BITS-1:0]       sample_in;
	logic [vfd_pkg::DELAY_BITS-1:0]      delay_time;

	modport source (output valid, output sample_in, output delay_time, input ready);
	modport sink   (input valid, input sample_in, input delay_time, output ready);
endinterface

interface vfd_out_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/vfd_store.sv =====
// ----------------------------------------------------------------------------
// Delay line sample store
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vfd_store #(
	parameter int DEPTH = 65536,
	parameter int WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;
endmodule

// ===== rtl/vfd_outq.sv =====
// ----------------------------------------------------------------------------
// Delay line result queue
// Small FIFO that decouples the datapath from the result consumer.
// ----------------------------------------------------------------------------
module vfd_outq #(
	parameter int WIDTH = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             valid,
	input  logic             ready,
	output logic [WIDTH-1:0] data
);
	logic [WIDTH-1:0]             entry_q [vfd_pkg::OUTQ_DEPTH];
	logic [vfd_pkg::OUTQ_AW-1:0]  wr_ptr_q;
	logic [vfd_pkg::OUTQ_AW-1:0]  rd_ptr_q;
	logic [vfd_pkg::CNT_BITS-1:0] count_q;
	logic                         pop;

	assign valid = (count_q != '0);
	assign pop   = valid && ready;
	assign data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

// ===== rtl/variable_fractional_delay_line_unit.sv =====
// ----------------------------------------------------------------------------
// Variable fractional delay line
// Each result passes the pipeline stages and then the result queue before it is offered.
// A new beat waits while the previous one makes the first of its two store reads.
// Reset: pointer and fill state clear at once; the store itself is not swept,
// since entries not yet written since reset are masked to zero on read.
// ----------------------------------------------------------------------------
module variable_fractional_delay_line_unit #(
	parameter int DEPTH       = 65536,
	parameter int SAMPLE_BITS = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	vfd_in_if.sink     din,
	vfd_out_if.source  dout
);
	localparam int AW  = $clog2(DEPTH);
	localparam int IPW = $clog2(DEPTH + 1);
	localparam int PW  = vfd_pkg::DELAY_FRAC_BITS + IPW;
	localparam int MW  = PW + 1;
	localparam int PRW = SAMPLE_BITS + vfd_pkg::WEIGHT_BITS + 2;
	localparam int WB  = vfd_pkg::WEIGHT_BITS;
	localparam int FB  = vfd_pkg::DELAY_FRAC_BITS;

	localparam logic [AW-1:0]  LAST_IDX = AW'(DEPTH - 1);
	localparam logic [IPW-1:0] DEPTH_IP = IPW'(DEPTH);
	localparam logic [AW:0]    DEPTH_X  = (AW + 1)'(DEPTH);

	// Write pointer and fill state.
	logic [AW-1:0]                wp_q;
	logic                         wrap_q;
	logic [vfd_pkg::CNT_BITS-1:0] cnt_q;

	logic                           in_acc;
	logic                           out_acc;
	logic [vfd_pkg::DELAY_BITS-1:0] d_sat;
	logic [MW-1:0]                  prod_full;

	// Pipeline stages.
	logic                          v_s1, v_s2, v_s3, v_s4;
	logic [PW-1:0]                 p_s1;
	logic [AW-1:0]                 wp_s1, wp_s2;
	logic                          wrap_s1, wrap_s2;
	logic [AW-1:0]                 pos0_s2;
	logic [WB-1:0]                 w_s2, w_s3;
	logic                          v0_s2, v1_s3;
	logic signed [SAMPLE_BITS-1:0] tap0_s3, tap0_s4;
	logic signed [PRW-1:0]         prod_s4;

	logic [IPW-1:0]                ipr;
	logic [AW-1:0]                 ip;
	logic [AW-1:0]                 pos0;
	logic                          v0;
	logic [AW-1:0]                 pos1;
	logic                          v1;
	logic [AW-1:0]                 rd_addr;
	logic [SAMPLE_BITS-1:0]        rd_data;
	logic signed [SAMPLE_BITS-1:0] tap1;
	logic signed [SAMPLE_BITS:0]   diff;
	logic signed [WB:0]            wgt;
	logic signed [PRW-1:0]         prod_c;
	logic signed [PRW-WB-1:0]      prod_hi;
	logic signed [PRW-WB-1:0]      mix;
	logic [SAMPLE_BITS-1:0]        result;

	// A new beat may enter while the previous one makes its second read.
	assign din.ready = !v_s1 && (cnt_q < vfd_pkg::CNT_BITS'(vfd_pkg::OUTQ_DEPTH));
	assign in_acc    = din.valid && din.ready;
	assign out_acc   = dout.valid && dout.ready;

	assign d_sat     = (din.delay_time > vfd_pkg::DELAY_ONE) ? vfd_pkg::DELAY_ONE
	                                                         : din.delay_time;
	assign prod_full = MW'(d_sat) * MW'(DEPTH);

	// Stage 1: tap position from the integer part of the scaled delay.
	// The integer part only reaches DEPTH for a delay of exactly 1.0.
	assign ipr = p_s1[PW-1:FB];
	assign ip  = (ipr == DEPTH_IP) ? '0 : ipr[AW-1:0];

	always_comb begin
		if (wp_s1 >= ip) begin
			pos0 = wp_s1 - ip;
		end else begin
			pos0 = AW'({1'b0, wp_s1} + DEPTH_X - {1'b0, ip});
		end
	end

	// Before the first wrap only entries up to the write pointer hold data.
	assign v0 = wrap_s1 || (pos0 <= wp_s1);

	// Stage 2: the next older tap.
	assign pos1 = (pos0_s2 == '0) ? LAST_IDX : pos0_s2 - 1'b1;
	assign v1   = wrap_s2 || (pos1 <= wp_s2);

	assign rd_addr = v_s2 ? pos1 : pos0;

	// Stage 3: weighted difference between the two taps.
	assign tap1   = v1_s3 ? $signed(rd_data) : '0;
	assign diff   = (SAMPLE_BITS + 1)'(tap1) - (SAMPLE_BITS + 1)'(tap0_s3);
	assign wgt    = $signed({1'b0, w_s3});
	assign prod_c = diff * wgt;

	// Stage 4: tap0 plus the floored fraction of the difference.
	assign prod_hi = prod_s4[PRW-1:WB];
	assign mix     = prod_hi + (PRW - WB)'(tap0_s4);
	assign result  = mix[SAMPLE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			wrap_q <= 1'b0;
			cnt_q  <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
		end else begin
			v_s1 <= in_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (in_acc) begin
				if (wp_q == LAST_IDX) begin
					wp_q   <= '0;
					wrap_q <= 1'b1;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
			end
			unique case ({in_acc, out_acc})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			p_s1    <= prod_full[PW-1:0];
			wp_s1   <= wp_q;
			wrap_s1 <= wrap_q;
		end
		if (v_s1) begin
			pos0_s2 <= pos0;
			v0_s2   <= v0;
			w_s2    <= p_s1[FB-1 -: WB];
			wp_s2   <= wp_s1;
			wrap_s2 <= wrap_s1;
		end
		if (v_s2) begin
			tap0_s3 <= v0_s2 ? $signed(rd_data) : '0;
			v1_s3   <= v1;
			w_s3    <= w_s2;
		end
		if (v_s3) begin
			prod_s4 <= prod_c;
			tap0_s4 <= tap0_s3;
		end
	end

	vfd_store #(
		.DEPTH (DEPTH),
		.WIDTH (SAMPLE_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (in_acc),
		.wr_addr (wp_q),
		.wr_data (din.sample_in),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	vfd_outq #(
		.WIDTH (SAMPLE_BITS)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s4),
		.push_data (result),
		.valid     (dout.valid),
		.ready     (dout.ready),
		.data      (dout.sample_out)
	);
endmodule

// ===== rtl/vfd_checker.sv =====
// ----------------------------------------------------------------------------
// Delay line port checker
// Watches the channel ports of the delay line for timing and handshake slips.
// ----------------------------------------------------------------------------
module vfd_checker #(
	parameter int SAMPLE_BITS = 24
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] sample_out
);
	localparam int LATENCY = 5;

	logic                         in_acc;
	logic                         out_acc;
	logic [vfd_pkg::CNT_BITS-1:0] cnt_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Beats taken but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			unique case ({in_acc, out_acc})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Two store reads per sample: no input beat right after another.
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input accepted on consecutive cycles");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> ##LATENCY out_valid)
		else $error("result not offered at the expected latency");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid || !in_ready) |-> (cnt_q != '0))
		else $error("result offered or input blocked with nothing outstanding");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(sample_out)))
		else $error("stalled result beat changed");
endmodule

bind variable_fractional_delay_line_unit vfd_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_vfd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (din.valid),
	.in_ready   (din.ready),
	.out_valid  (dout.valid),
	.out_ready  (dout.ready),
	.sample_out (dout.sample_out)
);

// ===== test/variable_fractional_delay_line_unit_test.sv =====
// ----------------------------------------------------------------------------
// Variable fractional delay line testbench
// Drives sample and delay beats through valid/ready with random gaps on both
// sides. A local model of the circular store predicts each interpolated tap,
// and the monitor checks every result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module variable_fractional_delay_line_unit_test;

	localparam int DEPTH         = 65536;
	localparam int SAMPLE_BITS   = 24;
	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 7;
	localparam int RANDOM_BEATS  = 1750;
	localparam int DRAIN_CYCLES  = 20;
	localparam int HOLD_START    = 600;
	localparam int HOLD_CYCLES   = 400;
	localparam int TIMEOUT_CYCLES = 1000000;

	typedef logic signed [SAMPLE_BITS-1:0]  sample_t;
	typedef logic [vfd_pkg::DELAY_BITS-1:0] delay_t;

	typedef struct packed {
		sample_t sample;
		delay_t  delay;
	} tap_beat_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic    in_valid  = 1'b0;
	sample_t in_sample = '0;
	delay_t  in_delay  = '0;
	logic    out_ready = 1'b0;
	logic    hold_off  = 1'b0;

	vfd_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) din_bus ();
	vfd_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) dout_bus ();

	assign din_bus.valid      = in_valid;
	assign din_bus.sample_in  = in_sample;
	assign din_bus.delay_time = in_delay;
	assign dout_bus.ready     = out_ready;

	variable_fractional_delay_line_unit #(
		.DEPTH(DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.din(din_bus),
		.dout(dout_bus)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Local copy of the circular store and its write pointer.
	sample_t     line_copy [DEPTH];
	int unsigned write_ptr = 0;

	tap_beat_t pending_beats [$];
	sample_t   expected_out [$];

	int beats_sent    = 0;
	int results_seen  = 0;
	int errors        = 0;
	int deepest_tap   = 0;
	int clamped_beats = 0;

	int send_gap  = 0;
	int send_calm = 0;
	int recv_gap  = 0;
	int recv_calm = 0;

	// Writes the sample, then blends the tap the delay points at with the
	// next older one, and queues the expected output.
	task automatic advance_delay_line(input sample_t sample, input delay_t delay);
		delay_t      d;
		logic [63:0] prod;
		int unsigned tap, pos0, pos1;
		longint      wt, a, b, mix;
		line_copy[write_ptr] = sample;
		if (delay > vfd_pkg::DELAY_ONE) begin
			d = vfd_pkg::DELAY_ONE;
			clamped_beats++;
		end else begin
			d = delay;
		end
		prod = 64'(d) * 64'(DEPTH);
		tap  = 32'((prod >> vfd_pkg::DELAY_FRAC_BITS) % 64'(DEPTH));
		wt   = longint'((prod & ((64'd1 << vfd_pkg::DELAY_FRAC_BITS) - 64'd1))
			>> (vfd_pkg::DELAY_FRAC_BITS - vfd_pkg::WEIGHT_BITS));
		pos0 = (write_ptr + DEPTH - tap) % DEPTH;
		pos1 = (pos0 == 0) ? DEPTH - 1 : pos0 - 1;
		a    = longint'(line_copy[pos0]);
		b    = longint'(line_copy[pos1]);
		mix  = a * ((longint'(1) << vfd_pkg::WEIGHT_BITS) - wt) + b * wt;
		expected_out.push_back(sample_t'(mix >>> vfd_pkg::WEIGHT_BITS));
		if (int'(tap) > deepest_tap)
			deepest_tap = tap;
		write_ptr = (write_ptr + 1) % DEPTH;
	endtask

	task automatic queue_beat(input sample_t sample, input delay_t delay);
		tap_beat_t beat;
		beat.sample = sample;
		beat.delay  = delay;
		pending_beats.push_back(beat);
	endtask

	// Mostly back to back or short gaps, now and then a long one.
	function automatic int pick_gap(input int calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm > 0 || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && din_bus.ready) begin
				advance_delay_line(in_sample, in_delay);
				beats_sent++;
				send_gap = pick_gap(send_calm);
				if (send_calm > 0)
					send_calm--;
				else if ($urandom_range(0, 149) == 0)
					send_calm = $urandom_range(30, 90);
			end
			if (!in_valid || din_bus.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					in_sample <= pending_beats[0].sample;
					in_delay  <= pending_beats[0].delay;
					void'(pending_beats.pop_front());
					in_valid  <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (dout_bus.valid && out_ready) begin
				results_seen++;
				if (expected_out.size() == 0) begin
					$error("sample_out: no result expected, got %0d", dout_bus.sample_out);
					errors++;
				end else begin
					if (dout_bus.sample_out !== expected_out[0]) begin
						$error("sample_out: expected %0d, got %0d",
							expected_out[0], dout_bus.sample_out);
						errors++;
					end
					void'(expected_out.pop_front());
				end
				recv_gap = pick_gap(recv_calm);
				if (recv_calm > 0)
					recv_calm--;
				else if ($urandom_range(0, 149) == 0)
					recv_calm = $urandom_range(30, 90);
			end else if (out_ready && $urandom_range(0, 7) == 0) begin
				recv_gap = pick_gap(recv_calm);
			end
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Long receiver stall while the sender keeps offering, so the result
	// queue fills and input ready drops.
	initial begin
		wait (beats_sent >= HOLD_START);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int written, tap, frac, kind;
		delay_t delay;
		for (int i = 0; i < DEPTH; i++)
			line_copy[i] = '0;

		// Directed: zero and full delay, values above one, sample extremes,
		// one-tap steps and the largest fraction.
		queue_beat(sample_t'(24'h7FFFFF), delay_t'(0));
		queue_beat(sample_t'(24'h800000), delay_t'(0));
		queue_beat(sample_t'(-1), delay_t'(1 << 8));
		queue_beat(sample_t'(1), delay_t'((1 << 8) | 8'h80));
		queue_beat(sample_t'(24'h7FFFFF), delay_t'((2 << 8) | 8'hFF));
		queue_beat(sample_t'(24'h800000), delay_t'(8'hFF));
		queue_beat(sample_t'(0), vfd_pkg::DELAY_ONE);
		queue_beat(sample_t'(24'h123456), vfd_pkg::DELAY_ONE);
		queue_beat(sample_t'(-24'sd4660), vfd_pkg::DELAY_ONE + delay_t'(1));
		queue_beat(sample_t'(24'h7FFFFF), {vfd_pkg::DELAY_BITS{1'b1}});
		queue_beat(sample_t'(24'h800000), vfd_pkg::DELAY_ONE - delay_t'(1));
		queue_beat(sample_t'(24'h55AA55), delay_t'((5 << 8) | 8'h01));
		queue_beat(sample_t'(24'hAA55AA), delay_t'((1 << 8) | 8'hFF));
		queue_beat(sample_t'(24'h7FFFFF), delay_t'((3 << 8) | 8'h40));
		queue_beat(sample_t'(24'h800000), delay_t'((12 << 8) | 8'hC0));
		queue_beat(sample_t'(24'h000001), delay_t'(8'h01));
		queue_beat(sample_t'(-1), delay_t'((15 << 8) | 8'h00));
		queue_beat(sample_t'(24'h400000), delay_t'((16 << 8) | 8'h80));

		// Random: most delays land on taps already written, the rest span
		// the whole field including values above one.
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			written = pending_beats.size();
			kind    = $urandom_range(0, 9);
			frac    = $urandom_range(0, 255);
			if (kind < 4) begin
				tap   = $urandom_range(0, (written < 16) ? written : 16);
				delay = delay_t'((tap << 8) | frac);
			end else if (kind < 7) begin
				tap   = $urandom_range(0, written);
				delay = delay_t'((tap << 8) | frac);
			end else if (kind < 9) begin
				delay = delay_t'($urandom);
			end else begin
				delay = vfd_pkg::DELAY_ONE
					+ delay_t'($urandom_range(0, (1 << vfd_pkg::DELAY_FRAC_BITS) - 1));
			end
			queue_beat(sample_t'($urandom), delay);
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_beats.size() > 0 || in_valid || expected_out.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d beats and checked %0d results; %0d delays were clamped to one.",
			beats_sent, results_seen, clamped_beats);
		$display("Deepest tap reached was %0d entries behind the write pointer.",
			deepest_tap);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
